[rtl/rtt_pkg.sv]
// rtt_pkg: shared types, codes and sizes of the retransmit timeout table
// used by every module of the block and by its checker
package rtt_pkg;

    localparam int SLOTS      = 16;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX     = 2'd1;

    localparam logic [3:0] TIMEOUT_RESET     = 4'd10;
    localparam logic [2:0] MAX_RESENDS_RESET = 3'd3;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_SEND = 2'd1,
        OP_ACK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        FLAG_CLEAR = 2'd0,
        FLAG_SENT  = 2'd1,
        FLAG_ACKED = 2'd2
    } flag_t;

    typedef struct packed {
        op_t               op;
        logic [SLOT_W-1:0] idx;
        logic [15:0]       packet;
        logic [7:0]        payload;
        logic [3:0]        limit;
        logic [2:0]        max_resends;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic        kind;
        logic [3:0]  slot;
        logic [15:0] packet;
        logic [7:0]  payload;
        logic [2:0]  attempt;
    } res_t;

endpackage

[rtl/retransmit_timeout_table.sv]
// retransmit_timeout_table: top level, config registers, front, queue and back
// depends on rtt_pkg, rtt_front, rtt_queue and rtt_back
//
// A command word is taken when start is high and busy is low; busy rises only
// when the four-word queue between front and back is full. The back runs a
// send or an ack as a single write to the table in idle. A tick is taken from
// the queue in idle, then the walk visits the table one slot per cycle through
// its single read-modify-write port, then a flush state releases the result
// held back so that it can carry last. Each timed-out slot gives one result
// word, shown for one cycle with strobe high, at most one per cycle; the
// receiver must take it then. Words with operation 3 and sends or acks to
// slots outside the table are dropped.
// Config writes are always ready and take effect for ticks accepted after.
module retransmit_timeout_table (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     operation,
    input  logic [3:0]                     slot,
    input  logic [15:0]                    packet_id,
    input  logic [7:0]                     payload_index,
    output logic                           strobe,
    output logic                           kind,
    output logic [3:0]                     out_slot,
    output logic [15:0]                    out_packet_id,
    output logic [7:0]                     out_payload_index,
    output logic [2:0]                     attempt,
    output logic                           last,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rtt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rtt_pkg::*;

    logic [3:0] timeout_reg, timeout_next;
    logic [2:0] max_reg, max_next;
    cmd_t       push_cmd, head_cmd;
    q_status_t  q_status;
    logic       push, pop;
    res_t       res;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        timeout_next = timeout_reg;
        max_next     = max_reg;
        if (cfg_valid)
        begin
            if (cfg_index == CFG_TIMEOUT)
            begin
                timeout_next = cfg_data[3:0];
            end
            else if (cfg_index == CFG_MAX)
            begin
                max_next = cfg_data[2:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
            max_reg     <= MAX_RESENDS_RESET;
        end
        else
        begin
            timeout_reg <= timeout_next;
            max_reg     <= max_next;
        end
    end

    rtt_front u_front (
        .start         (start),
        .operation     (operation),
        .slot          (slot),
        .packet_id     (packet_id),
        .payload_index (payload_index),
        .timeout_ticks (timeout_reg),
        .max_resends   (max_reg),
        .q_status      (q_status),
        .busy          (busy),
        .push          (push),
        .cmd           (push_cmd)
    );

    rtt_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (push_cmd),
        .pop    (pop),
        .dout   (head_cmd),
        .status (q_status)
    );

    rtt_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .strobe   (strobe),
        .last     (last),
        .res      (res)
    );

    assign kind              = res.kind;
    assign out_slot          = res.slot;
    assign out_packet_id     = res.packet;
    assign out_payload_index = res.payload;
    assign attempt           = res.attempt;

endmodule

[rtl/rtt_queue.sv]
// rtt_queue: small command queue between front and back
// depends on rtt_pkg for cmd_t and the queue depth
module rtt_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  rtt_pkg::cmd_t      din,
    input  logic               pop,
    output rtt_pkg::cmd_t      dout,
    output rtt_pkg::q_status_t status
);
    import rtt_pkg::*;

    cmd_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign status.full  = (count_reg == QCNT_W'(QDEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign dout         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/rtt_front.sv]
// rtt_front: accepts command words, drops the ones that do nothing, queues the rest
// depends on rtt_pkg for cmd_t and the operation codes
module rtt_front (
    input  logic               start,
    input  logic [1:0]         operation,
    input  logic [3:0]         slot,
    input  logic [15:0]        packet_id,
    input  logic [7:0]         payload_index,
    input  logic [3:0]         timeout_ticks,
    input  logic [2:0]         max_resends,
    input  rtt_pkg::q_status_t q_status,
    output logic               busy,
    output logic               push,
    output rtt_pkg::cmd_t      cmd
);
    import rtt_pkg::*;

    logic in_range;
    logic useful;

    assign busy     = q_status.full;
    assign in_range = (32'(slot) < SLOTS);

    always_comb
    begin
        unique case (operation)
            OP_TICK:         useful = 1'b1;
            OP_SEND, OP_ACK: useful = in_range;
            default:         useful = 1'b0;
        endcase
    end

    assign push = start && !q_status.full && useful;

    // config is sampled with the word so a later write cannot reach it
    always_comb
    begin
        cmd.op          = op_t'(operation);
        cmd.idx         = SLOT_W'(slot);
        cmd.packet      = packet_id;
        cmd.payload     = payload_index;
        cmd.limit       = (timeout_ticks == 4'd0) ? 4'd1 : timeout_ticks;
        cmd.max_resends = max_resends;
    end

endmodule

[rtl/rtt_back.sv]
// rtt_back: slot table, executes queued send, ack and tick words
// depends on rtt_pkg for cmd_t, res_t and the slot flags
module rtt_back (
    input  logic               clk,
    input  logic               rst_n,
    input  rtt_pkg::cmd_t      cmd,
    input  rtt_pkg::q_status_t q_status,
    output logic               pop,
    output logic               strobe,
    output logic               last,
    output rtt_pkg::res_t      res
);
    import rtt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_FLUSH = 3'b100
    } bstate_t;

    flag_t       flag_reg    [SLOTS];
    logic [3:0]  wait_reg    [SLOTS];
    logic [2:0]  retry_reg   [SLOTS];
    logic [15:0] packet_reg  [SLOTS];
    logic [7:0]  payload_mem [SLOTS];

    bstate_t           state_reg, state_next;
    logic [SLOT_W-1:0] walk_reg, walk_next;
    logic [3:0]        limit_reg, limit_next;
    logic [2:0]        max_reg, max_next;
    logic              held_valid_reg, held_valid_next;
    res_t              held_reg, held_next;
    logic              strobe_reg, strobe_next;
    logic              last_reg, last_next;
    res_t              res_reg, res_next;

    logic [SLOT_W-1:0] rd_idx;
    flag_t             flag_rd, flag_w;
    logic [3:0]        wait_rd, wait_w;
    logic [2:0]        retry_rd, retry_w;
    logic [15:0]       packet_rd, packet_w;
    logic [7:0]        payload_rd;
    logic              wr_en, pay_en;
    logic              timed, give_up;
    res_t              cand;

    assign rd_idx     = (state_reg == ST_WALK) ? walk_reg : cmd.idx;
    assign flag_rd    = flag_reg[rd_idx];
    assign wait_rd    = wait_reg[rd_idx];
    assign retry_rd   = retry_reg[rd_idx];
    assign packet_rd  = packet_reg[rd_idx];
    assign payload_rd = payload_mem[rd_idx];

    assign timed   = (wait_rd >= limit_reg);
    assign give_up = (retry_rd >= max_reg);

    always_comb
    begin
        cand.kind    = give_up;
        cand.slot    = 4'(walk_reg);
        cand.packet  = packet_rd;
        cand.payload = payload_rd;
        cand.attempt = retry_rd;
    end

    always_comb
    begin
        state_next      = state_reg;
        walk_next       = walk_reg;
        limit_next      = limit_reg;
        max_next        = max_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;
        strobe_next     = 1'b0;
        last_next       = 1'b0;
        res_next        = res_reg;
        pop             = 1'b0;
        wr_en           = 1'b0;
        pay_en          = 1'b0;
        flag_w          = flag_rd;
        wait_w          = wait_rd;
        retry_w         = retry_rd;
        packet_w        = packet_rd;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    pop = 1'b1;
                    unique case (cmd.op)
                        OP_SEND:
                        begin
                            wr_en    = 1'b1;
                            pay_en   = 1'b1;
                            flag_w   = FLAG_SENT;
                            packet_w = cmd.packet;
                            wait_w   = 4'd0;
                            retry_w  = 3'd0;
                        end
                        OP_ACK:
                        begin
                            wr_en  = 1'b1;
                            flag_w = FLAG_ACKED;
                        end
                        default:
                        begin
                            state_next = ST_WALK;
                            walk_next  = '0;
                            limit_next = cmd.limit;
                            max_next   = cmd.max_resends;
                        end
                    endcase
                end
            end
            ST_WALK:
            begin
                wr_en = 1'b1;
                if (!timed)
                begin
                    if (flag_rd == FLAG_SENT)
                    begin
                        wait_w = wait_rd + 4'd1;
                    end
                    else if (flag_rd == FLAG_ACKED)
                    begin
                        flag_w   = FLAG_CLEAR;
                        packet_w = 16'd0;
                        wait_w   = 4'd0;
                        retry_w  = 3'd0;
                    end
                end
                else
                begin
                    wait_w = 4'd0;
                    if (give_up)
                    begin
                        flag_w   = FLAG_CLEAR;
                        packet_w = 16'd0;
                        retry_w  = 3'd0;
                    end
                    else
                    begin
                        retry_w = retry_rd + 3'd1;
                    end
                    // the held result is not the last one, a newer one replaces it
                    if (held_valid_reg)
                    begin
                        strobe_next = 1'b1;
                        res_next    = held_reg;
                    end
                    held_valid_next = 1'b1;
                    held_next       = cand;
                end
                if (walk_reg == SLOT_W'(SLOTS - 1))
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    walk_next = walk_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (held_valid_reg)
                begin
                    strobe_next = 1'b1;
                    last_next   = 1'b1;
                    res_next    = held_reg;
                end
                held_valid_next = 1'b0;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            walk_reg       <= '0;
            limit_reg      <= TIMEOUT_RESET;
            max_reg        <= MAX_RESENDS_RESET;
            held_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
            last_reg       <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                flag_reg[i]   <= FLAG_CLEAR;
                wait_reg[i]   <= 4'd0;
                retry_reg[i]  <= 3'd0;
                packet_reg[i] <= 16'd0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            walk_reg       <= walk_next;
            limit_reg      <= limit_next;
            max_reg        <= max_next;
            held_valid_reg <= held_valid_next;
            strobe_reg     <= strobe_next;
            last_reg       <= last_next;
            if (wr_en)
            begin
                flag_reg[rd_idx]   <= flag_w;
                wait_reg[rd_idx]   <= wait_w;
                retry_reg[rd_idx]  <= retry_w;
                packet_reg[rd_idx] <= packet_w;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg <= held_next;
        res_reg  <= res_next;
        if (pay_en)
        begin
            payload_mem[rd_idx] <= cmd.payload;
        end
    end

    assign strobe = strobe_reg;
    assign last   = last_reg;
    assign res    = res_reg;

endmodule

[rtl/rtt_checker.sv]
// rtt_checker: port-level assertions for retransmit_timeout_table, with its bind
// depends on rtt_pkg for config codes and reset values
module rtt_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           strobe,
    input logic                           kind,
    input logic [2:0]                     attempt,
    input logic                           last,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [rtt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [rtt_pkg::CFG_DATA_W-1:0] cfg_data
);
    import rtt_pkg::*;

    logic [2:0] max_sh_reg, max_sh_next;

    // shadow of the resend limit as written on the port
    always_comb
    begin
        max_sh_next = max_sh_reg;
        if (cfg_valid && cfg_ready && (cfg_index == CFG_MAX))
        begin
            max_sh_next = cfg_data[2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_sh_reg <= MAX_RESENDS_RESET;
        end
        else
        begin
            max_sh_reg <= max_sh_next;
        end
    end

    a_resend_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !kind |-> attempt < max_sh_reg)
        else $error("resend word with retries used up");

    a_giveup_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && kind |-> attempt >= max_sh_reg)
        else $error("give-up word before retries used up");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("result word right after the last word of a tick");

endmodule

bind retransmit_timeout_table rtt_checker u_rtt_checker (.*);
